/* hdl/next_fit_bitmap_allocator_macros.svh */
// ----------------------------------------------------------------------------
// next_fit_bitmap_allocator_macros
// Assertion macros for the next-fit bitmap allocator; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BITMAP_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define NFBA_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("nfba assertion failed");
// Next-cycle implication
`define NFBA_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("nfba assertion failed");
`else
`define NFBA_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons)
`define NFBA_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

/* hdl/nfba_pkg.sv */
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package nfba_pkg;

    localparam int MAX_CLUSTERS = 65536;
    localparam int MAP_BYTES    = MAX_CLUSTERS / 8;
    localparam int ADDR_W       = $clog2(MAP_BYTES);
    localparam int CNT_W        = $clog2(MAX_CLUSTERS) + 1;
    localparam int IDX_W        = 16;
    localparam int CFG_W        = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_W         = 24;
    localparam int OUT_W        = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_FORMAT = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic full_set;
        logic range_set;
        logic scan_run;
        logic free_chk;
        logic sweep_run;
    } dp_ctl_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic map_full;
        logic range_err;
        logic found;
        logic exhausted;
        logic sweep_last;
    } dp_sts_t;

endpackage

/* hdl/nfba_ctrl.sv */
// ----------------------------------------------------------------------------
// nfba_ctrl
// Sequencer for the allocator: clear after reset, decode each request and
// step the datapath through scan, free and format sweeps.
// ----------------------------------------------------------------------------
module nfba_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_busy,
    output logic               out_load,
    input  nfba_pkg::dp_sts_t  sts,
    output nfba_pkg::dp_ctl_t  ctl
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_FORMAT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.sweep_run = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    nfba_pkg::CMD_ALLOC:
                    begin
                        if (sts.map_full)
                        begin
                            ctl.full_set = 1'b1;
                            state_next   = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    nfba_pkg::CMD_FREE:
                    begin
                        if (sts.range_err)
                        begin
                            ctl.range_set = 1'b1;
                            state_next    = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                    nfba_pkg::CMD_FORMAT:
                    begin
                        state_next = S_FORMAT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_run = 1'b1;
                if (sts.found || sts.exhausted)
                begin
                    state_next = S_RESULT;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                ctl.free_chk = 1'b1;
                state_next   = S_RESULT;
            end
            S_FORMAT:
            begin
                ctl.sweep_run = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/nfba_datapath.sv */
// ----------------------------------------------------------------------------
// nfba_datapath
// Allocation map memory, cursor, used count, configuration registers and the
// byte scan, free and sweep logic driven by the controller.
// ----------------------------------------------------------------------------
`include "next_fit_bitmap_allocator_macros.svh"

module nfba_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfba_pkg::CFG_W-1:0]          cfg_data,
    input  nfba_pkg::cmd_t                      in_cmd,
    input  logic [nfba_pkg::IDX_W-1:0]          in_cluster_index,
    input  nfba_pkg::dp_ctl_t                   ctl,
    output nfba_pkg::dp_sts_t                   sts,
    output logic [nfba_pkg::IDX_W-1:0]          allocated_index,
    output nfba_pkg::status_t                   status,
    output logic [nfba_pkg::CNT_W-1:0]          free_count
);

    localparam int AW = nfba_pkg::ADDR_W;
    localparam int CW = nfba_pkg::CNT_W;
    localparam int IW = nfba_pkg::IDX_W;

    // Allocation map
    logic [7:0]          map_mem [nfba_pkg::MAP_BYTES];
    logic [7:0]          rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;

    // Configuration and state
    logic [nfba_pkg::CFG_W-1:0] total_reg;
    logic [nfba_pkg::CFG_W-1:0] reserved_reg;
    nfba_pkg::cmd_t      cmd_reg;
    logic [IW-1:0]       ci_reg;
    logic [IW-1:0]       cursor_reg;
    logic [CW-1:0]       used_reg;
    logic [CW-1:0]       fmt_n_reg;
    logic [IW-1:0]       granted_reg;
    nfba_pkg::status_t   status_reg;

    // Scan pipeline
    logic [AW-1:0]       scan_addr_reg;
    logic [AW:0]         chk_cnt_reg;
    logic                data_vld_reg;
    logic [AW-1:0]       data_addr_reg;
    logic [AW-1:0]       sweep_addr_reg;

    logic [CW-1:0]       eff_total;
    logic [CW-1:0]       eff_p7;
    logic [AW:0]         nbytes;
    logic [CW-1:0]       res_n;
    logic [IW-1:0]       cur_eff;
    logic [AW:0]         scan_inc;
    logic [7:0]          cand;
    logic                hit;
    logic [2:0]          hit_j;
    logic [IW-1:0]       hit_idx;
    logic [CW-1:0]       hit_next;
    logic [7:0]          hit_mask;
    logic                scan_found;
    logic                scan_exhausted;
    logic [7:0]          fr_mask;
    logic                fr_set;
    logic                free_we;
    logic                sweep_we;
    logic [CW-1:0]       sweep_base;
    logic [CW-1:0]       sweep_hi;
    logic [7:0]          sweep_byte;
    logic                sweep_last;

    // Effective total, byte count and reserved count
    always_comb
    begin
        if (total_reg == '0)
        begin
            eff_total = CW'(1);
        end
        else if (total_reg > CW'(nfba_pkg::MAX_CLUSTERS))
        begin
            eff_total = CW'(nfba_pkg::MAX_CLUSTERS);
        end
        else
        begin
            eff_total = total_reg;
        end
    end

    assign eff_p7  = eff_total + CW'(7);
    assign nbytes  = eff_p7[CW-1:3];
    assign res_n   = (reserved_reg > eff_total) ? eff_total : reserved_reg;
    assign cur_eff = ({1'b0, cursor_reg} < eff_total) ? cursor_reg : '0;
    assign scan_inc = {1'b0, scan_addr_reg} + (AW+1)'(1);

    // Find the first clear bit below the total, MSB first
    always_comb
    begin
        hit   = 1'b0;
        hit_j = '0;
        for (int j = 0; j < 8; j++)
        begin
            cand[j] = !rd_data_reg[7-j] && ({1'b0, data_addr_reg, 3'(j)} < eff_total);
        end
        for (int j = 7; j >= 0; j--)
        begin
            if (cand[j])
            begin
                hit   = 1'b1;
                hit_j = 3'(j);
            end
        end
    end

    assign hit_idx        = {data_addr_reg, hit_j};
    assign hit_next       = {1'b0, hit_idx} + CW'(1);
    assign hit_mask       = 8'h80 >> hit_j;
    assign scan_found     = ctl.scan_run && data_vld_reg && hit;
    assign scan_exhausted = ctl.scan_run && data_vld_reg && !hit
                            && (chk_cnt_reg == (nbytes - (AW+1)'(1)));

    // Free bit test
    assign fr_mask = 8'h80 >> ci_reg[2:0];
    assign fr_set  = |(rd_data_reg & fr_mask);
    assign free_we = ctl.free_chk && fr_set;

    // Sweep byte: leading ones for clusters below the reserved count
    assign sweep_base = {1'b0, sweep_addr_reg, 3'b000};
    assign sweep_hi   = sweep_base + CW'(8);
    assign sweep_last = ctl.sweep_run && (sweep_addr_reg == AW'(nfba_pkg::MAP_BYTES - 1));
    assign sweep_we   = ctl.sweep_run;

    always_comb
    begin
        if (fmt_n_reg >= sweep_hi)
        begin
            sweep_byte = 8'hFF;
        end
        else if (fmt_n_reg <= sweep_base)
        begin
            sweep_byte = 8'h00;
        end
        else
        begin
            sweep_byte = ~(8'hFF >> fmt_n_reg[2:0]);
        end
    end

    // Memory ports
    assign rd_addr = (cmd_reg == nfba_pkg::CMD_FREE) ? ci_reg[IW-1:3] : scan_addr_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_addr_reg;
        wr_data = sweep_byte;
        if (sweep_we)
        begin
            wr_en = 1'b1;
        end
        else if (scan_found)
        begin
            wr_en   = 1'b1;
            wr_addr = data_addr_reg;
            wr_data = rd_data_reg | hit_mask;
        end
        else if (free_we)
        begin
            wr_en   = 1'b1;
            wr_addr = ci_reg[IW-1:3];
            wr_data = rd_data_reg & ~fr_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= nfba_pkg::CFG_W'(65536);
            reserved_reg   <= nfba_pkg::CFG_W'(3);
            cmd_reg        <= nfba_pkg::CMD_NOP;
            cursor_reg     <= '0;
            used_reg       <= '0;
            fmt_n_reg      <= '0;
            scan_addr_reg  <= '0;
            chk_cnt_reg    <= '0;
            data_vld_reg   <= 1'b0;
            sweep_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nfba_pkg::REG_TOTAL:    total_reg    <= cfg_data;
                    nfba_pkg::REG_RESERVED: reserved_reg <= cfg_data;
                    default:                total_reg    <= total_reg;
                endcase
            end
            if (ctl.accept)
            begin
                cmd_reg        <= in_cmd;
                fmt_n_reg      <= res_n;
                scan_addr_reg  <= cur_eff[IW-1:3];
                chk_cnt_reg    <= '0;
                data_vld_reg   <= 1'b0;
                sweep_addr_reg <= '0;
            end
            // Advance the scan one byte a cycle
            if (ctl.scan_run)
            begin
                data_vld_reg  <= 1'b1;
                scan_addr_reg <= (scan_inc >= nbytes) ? '0 : scan_inc[AW-1:0];
                if (data_vld_reg)
                begin
                    chk_cnt_reg <= chk_cnt_reg + (AW+1)'(1);
                end
            end
            if (scan_found)
            begin
                used_reg   <= used_reg + CW'(1);
                cursor_reg <= (hit_next >= eff_total) ? '0 : hit_next[IW-1:0];
            end
            if (free_we && (used_reg != '0))
            begin
                used_reg <= used_reg - CW'(1);
            end
            // Sweep the whole map, then set count and cursor
            if (ctl.sweep_run)
            begin
                sweep_addr_reg <= sweep_addr_reg + AW'(1);
                if (sweep_last)
                begin
                    used_reg   <= fmt_n_reg;
                    cursor_reg <= (fmt_n_reg >= eff_total) ? '0 : fmt_n_reg[IW-1:0];
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            ci_reg      <= in_cluster_index;
            granted_reg <= '0;
            status_reg  <= nfba_pkg::ST_OK;
        end
        if (ctl.scan_run)
        begin
            data_addr_reg <= scan_addr_reg;
        end
        if (ctl.full_set || scan_exhausted)
        begin
            status_reg <= nfba_pkg::ST_FULL;
        end
        if (ctl.range_set)
        begin
            status_reg <= nfba_pkg::ST_RANGE;
        end
        if (ctl.free_chk && !fr_set)
        begin
            status_reg <= nfba_pkg::ST_NOT_USED;
        end
        if (scan_found)
        begin
            granted_reg <= hit_idx;
        end
    end

    // Status to the controller and result fields
    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.map_full   = (used_reg >= eff_total);
        sts.range_err  = ({1'b0, ci_reg} >= eff_total);
        sts.found      = scan_found;
        sts.exhausted  = scan_exhausted;
        sts.sweep_last = sweep_last;
    end

    assign allocated_index = granted_reg;
    assign status          = status_reg;
    assign free_count      = (used_reg > eff_total) ? '0 : (eff_total - used_reg);

    `NFBA_ASSERT_NEXT(a_grant_below_total, clk, rst_n, scan_found, ({1'b0, granted_reg} < $past(eff_total)))
    `NFBA_ASSERT_NEXT(a_used_bounded, clk, rst_n, scan_found, (used_reg <= $past(eff_total)))
    `NFBA_ASSERT_IMPL(a_single_writer, clk, rst_n, 1'b1, $onehot0({sweep_we, scan_found, free_we}))

endmodule

/* hdl/next_fit_bitmap_allocator.sv */
// Allocate: decode, then scan map bytes from the cursor until a clear bit is found or
// every byte is checked. Free: decode, map read, bit check. Out-of-range free, full map
// and no-op requests go from decode to the result. Format: a one-byte-a-cycle write
// sweep of the 8192-byte map. One request at a time; the next is taken while the
// previous result waits. Reset clears the map in a sweep with s_tready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// next_fit_bitmap_allocator
// Next-fit cluster allocator over a one-bit-per-cluster map held in memory,
// with allocate, free and format requests on a stream interface.
// ----------------------------------------------------------------------------
module next_fit_bitmap_allocator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [nfba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfba_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nfba_pkg::IN_W-1:0]          s_tdata,   // cmd[1:0], cluster_index[17:2]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nfba_pkg::OUT_W-1:0]         m_tdata    // allocated_index[15:0],
                                                          // status[17:16], free_count[34:18]
);

    nfba_pkg::dp_ctl_t                 ctl;
    nfba_pkg::dp_sts_t                 sts;
    logic                              out_load;
    logic                              out_busy;
    logic [nfba_pkg::IDX_W-1:0]        allocated_index;
    nfba_pkg::status_t                 status;
    logic [nfba_pkg::CNT_W-1:0]        free_count;
    logic                              out_vld_reg;
    logic [nfba_pkg::OUT_W-1:0]        out_data_reg;

    nfba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_busy (out_busy),
        .out_load (out_load),
        .sts      (sts),
        .ctl      (ctl)
    );

    nfba_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_cmd           (nfba_pkg::cmd_t'(s_tdata[1:0])),
        .in_cluster_index (s_tdata[17:2]),
        .ctl              (ctl),
        .sts              (sts),
        .allocated_index  (allocated_index),
        .status           (status),
        .free_count       (free_count)
    );

    // Output register: hold the result until taken
    assign out_busy = out_vld_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {5'b0, free_count, status, allocated_index};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
